// ----- hdl/kvila_pkg.sv -----
`timescale 1ns / 1ps
package kvila_pkg;

   localparam logic [1:0] KIND_KEY = 2'd0;
   localparam logic [1:0] KIND_SET = 2'd1;
   localparam logic [1:0] KIND_GET = 2'd2;
   localparam logic [1:0] KIND_DEL = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NO_SPACE  = 2'd3;

   localparam logic CSR_BASE = 1'b0;
   localparam logic CSR_SIZE = 1'b1;

   localparam logic RT_REPLY = 1'b0;
   localparam logic RT_COPY  = 1'b1;

   localparam int HASH_SHIFT = 5;
   localparam logic [31:0] RECORD_BYTES = 32'd12;
   localparam logic [24:0] SIZE_RESET = 25'd4096;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] id;
      logic [15:0] len;
   } cmd_type;

   typedef struct packed {
      logic        result_type;
      logic [1:0]  status;
      logic [3:0]  slot;
      logic [31:0] data_address;
      logic [31:0] source_address;
      logic [15:0] length;
      logic [31:0] record_address;
      logic [31:0] key_id;
      logic        switched;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_READ,
      BK_EVAL,
      BK_DECIDE,
      BK_CHECK,
      BK_CREAD,
      BK_CEVAL,
      BK_SWAP,
      BK_STORE
   } bk_state_type;

endpackage

// ----- hdl/kvila_fifo.sv -----
`timescale 1ns / 1ps
module kvila_fifo #(
   parameter int W = 50
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] rdata,
   output logic         empty
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;

   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ----- hdl/kvila_front.sv -----
`timescale 1ns / 1ps
module kvila_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,
   input  logic [23:0]         req_tdata,
   input  logic                q_full,
   output logic                q_push,
   output kvila_pkg::cmd_type  q_cmd
);
   import kvila_pkg::*;

   logic [31:0] hash_ff, hash_in;
   logic        acc;

   assign req_tready = ~q_full;
   assign acc        = req_tvalid & req_tready;
   assign q_push     = acc & (req_tuser != KIND_KEY);

   always_comb begin
      q_cmd.kind = req_tuser;
      q_cmd.id   = hash_ff;
      q_cmd.len  = req_tdata[23:8];
      hash_in    = hash_ff;
      if (acc) begin
         if (req_tuser == KIND_KEY) begin
            hash_in = (hash_ff << HASH_SHIFT) + hash_ff + {24'd0, req_tdata[7:0]};
         end else begin
            hash_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end
endmodule

// ----- hdl/kvila_back.sv -----
`timescale 1ns / 1ps
module kvila_back #(
   parameter int PAIRS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [31:0]         csr_data,
   input  logic                q_empty,
   input  kvila_pkg::cmd_type  q_cmd,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output kvila_pkg::rsp_type  rsp
);
   import kvila_pkg::*;

   localparam int IW = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(PAIRS - 1);

   bk_state_type state_ff, state_in;
   logic [31:0] base_ff, base_nx;
   logic [24:0] size_ff, size_nx;
   logic        active_ff, active_in;
   logic [31:0] icur_ff, icur_in, dcur_ff, dcur_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic        mf_ff, mf_in, ff_ff, ff_in, sw_ff, sw_in;
   logic [IW-1:0] midx_ff, midx_in, fidx_ff, fidx_in;
   logic [31:0] maddr_ff, maddr_in, dt_ff, dt_in, dd_ff, dd_in;
   logic [15:0] mlen_ff, mlen_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [PAIRS-1:0] valid_ff;

   logic [31:0] mem_id [PAIRS];
   logic [31:0] mem_ad [PAIRS];
   logic [15:0] mem_ln [PAIRS];
   logic        rd_v_ff;
   logic [31:0] rd_id_ff, rd_ad_ff;
   logic [15:0] rd_ln_ff;

   logic          mem_we, v_we, v_val;
   logic [IW-1:0] mem_wa, v_wa;
   logic [31:0]   mem_wid, mem_wad;
   logic [15:0]   mem_wln;

   logic [31:0] size32, ib0, ib1, db0, db1, ib_act, db_act, ib_oth, db_oth;
   logic [31:0] e_id, e_ad;
   logic [15:0] e_ln;
   logic        ovf, e_match, e_free, e_live, out_free, rsp_load;

   assign size32 = {7'd0, size_ff};
   assign ib0    = base_ff;
   assign ib1    = base_ff + size32;
   assign db0    = base_ff + (size32 << 1);
   assign db1    = db0 + size32;
   assign ib_act = active_ff ? ib1 : ib0;
   assign db_act = active_ff ? db1 : db0;
   assign ib_oth = active_ff ? ib0 : ib1;
   assign db_oth = active_ff ? db0 : db1;

   assign ovf = ({2'd0, icur_ff} + 34'(RECORD_BYTES) > {2'd0, ib_act} + 34'(size_ff)) ||
                ({2'd0, dcur_ff} + 34'(len_ff) > {2'd0, db_act} + 34'(size_ff));

   assign e_id    = rd_v_ff ? rd_id_ff : '0;
   assign e_ad    = rd_v_ff ? rd_ad_ff : '0;
   assign e_ln    = rd_v_ff ? rd_ln_ff : '0;
   assign e_match = e_id == id_ff;
   assign e_free  = (e_id == '0) && (e_ad == '0) && (e_ln == '0);
   assign e_live  = (e_id != '0) && (e_ad != '0) && (e_ln != '0) && (e_ad >= db_act) &&
                    ({1'b0, e_ad} < {1'b0, db_act} + 33'(size_ff));

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      base_nx = base_ff;
      size_nx = size_ff;
      if (csr_index == CSR_BASE) begin
         base_nx = csr_data;
      end else begin
         size_nx = csr_data[24:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      icur_in   = icur_ff;
      dcur_in   = dcur_ff;
      ptr_in    = ptr_ff;
      kind_in   = kind_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      mf_in     = mf_ff;
      ff_in     = ff_ff;
      sw_in     = sw_ff;
      midx_in   = midx_ff;
      fidx_in   = fidx_ff;
      maddr_in  = maddr_ff;
      mlen_in   = mlen_ff;
      dt_in     = dt_ff;
      dd_in     = dd_ff;
      q_pop     = 1'b0;
      rsp_load  = 1'b0;
      rsp_in    = '0;
      rsp_in.key_id = id_ff;
      rsp_in.last   = 1'b1;
      rsp_in.switched = sw_ff;
      mem_we  = 1'b0;
      mem_wa  = fidx_ff;
      mem_wid = id_ff;
      mem_wad = '0;
      mem_wln = '0;
      v_we    = 1'b0;
      v_wa    = fidx_ff;
      v_val   = 1'b1;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               kind_in  = q_cmd.kind;
               id_in    = q_cmd.id;
               len_in   = q_cmd.len;
               mf_in    = 1'b0;
               ff_in    = 1'b0;
               sw_in    = 1'b0;
               ptr_in   = '0;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_EVAL;
         end
         BK_EVAL: begin
            if (e_match && !mf_ff) begin
               mf_in    = 1'b1;
               midx_in  = ptr_ff;
               maddr_in = e_ad;
               mlen_in  = e_ln;
            end
            if ((e_match || e_free) && !ff_ff) begin
               ff_in   = 1'b1;
               fidx_in = ptr_ff;
            end
            if (ptr_ff == LAST_IDX) begin
               state_in = BK_DECIDE;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = BK_READ;
            end
         end
         BK_DECIDE: begin
            if (kind_ff == KIND_SET) begin
               if (!mf_ff && !ff_ff) begin
                  rsp_in.status = ST_FULL;
                  if (out_free) begin
                     rsp_load = 1'b1;
                     state_in = BK_IDLE;
                  end
               end else begin
                  if (!mf_ff) begin
                     mem_we = 1'b1;
                     v_we   = 1'b1;
                  end
                  state_in = BK_CHECK;
               end
            end else if (!mf_ff) begin
               rsp_in.status = ST_NOT_FOUND;
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = BK_IDLE;
               end
            end else begin
               rsp_in.slot = 4'(midx_ff);
               if (kind_ff == KIND_GET) begin
                  rsp_in.data_address = maddr_ff;
                  rsp_in.length       = mlen_ff;
               end
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = BK_IDLE;
                  if (kind_ff == KIND_DEL) begin
                     v_we  = 1'b1;
                     v_wa  = midx_ff;
                     v_val = 1'b0;
                  end
               end
            end
         end
         BK_CHECK: begin
            if (!ovf) begin
               state_in = BK_STORE;
            end else if (!sw_ff) begin
               sw_in    = 1'b1;
               dt_in    = ib_oth + RECORD_BYTES;
               dd_in    = db_oth;
               ptr_in   = '0;
               state_in = BK_CREAD;
            end else begin
               rsp_in.status = ST_NO_SPACE;
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = BK_IDLE;
               end
            end
         end
         BK_CREAD: begin
            state_in = BK_CEVAL;
         end
         BK_CEVAL: begin
            rsp_in.result_type    = RT_COPY;
            rsp_in.slot           = 4'(ptr_ff);
            rsp_in.data_address   = dd_ff;
            rsp_in.source_address = e_ad;
            rsp_in.length         = e_ln;
            rsp_in.record_address = dt_ff;
            rsp_in.key_id         = e_id;
            rsp_in.last           = 1'b0;
            if (!e_live || out_free) begin
               if (e_live) begin
                  rsp_load = 1'b1;
                  dt_in    = dt_ff + RECORD_BYTES;
                  dd_in    = dd_ff + {16'd0, e_ln};
               end
               if (ptr_ff == LAST_IDX) begin
                  state_in = BK_SWAP;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = BK_CREAD;
               end
            end
         end
         BK_SWAP: begin
            icur_in   = dt_ff;
            dcur_in   = dd_ff;
            active_in = ~active_ff;
            state_in  = BK_CHECK;
         end
         BK_STORE: begin
            rsp_in.slot           = 4'(fidx_ff);
            rsp_in.data_address   = dcur_ff;
            rsp_in.length         = len_ff;
            rsp_in.record_address = icur_ff;
            if (out_free) begin
               rsp_load = 1'b1;
               mem_we   = 1'b1;
               mem_wad  = dcur_ff;
               mem_wln  = len_ff;
               v_we     = 1'b1;
               icur_in  = icur_ff + RECORD_BYTES;
               dcur_in  = dcur_ff + {16'd0, len_ff};
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_id[mem_wa] <= mem_wid;
         mem_ad[mem_wa] <= mem_wad;
         mem_ln[mem_wa] <= mem_wln;
      end
      rd_id_ff <= mem_id[ptr_ff];
      rd_ad_ff <= mem_ad[ptr_ff];
      rd_ln_ff <= mem_ln[ptr_ff];
      rd_v_ff  <= valid_ff[ptr_ff];
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      id_ff    <= id_in;
      len_ff   <= len_in;
      mf_ff    <= mf_in;
      ff_ff    <= ff_in;
      sw_ff    <= sw_in;
      midx_ff  <= midx_in;
      fidx_ff  <= fidx_in;
      maddr_ff <= maddr_in;
      mlen_ff  <= mlen_in;
      dt_ff    <= dt_in;
      dd_ff    <= dd_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         base_ff      <= '0;
         size_ff      <= SIZE_RESET;
         active_ff    <= 1'b0;
         icur_ff      <= RECORD_BYTES;
         dcur_ff      <= {6'd0, SIZE_RESET, 1'b0};
      end else if (csr_we) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         base_ff      <= base_nx;
         size_ff      <= size_nx;
         active_ff    <= 1'b0;
         icur_ff      <= base_nx + RECORD_BYTES;
         dcur_ff      <= base_nx + {6'd0, size_nx, 1'b0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         active_ff    <= active_in;
         icur_ff      <= icur_in;
         dcur_ff      <= dcur_in;
         if (v_we) begin
            valid_ff[v_wa] <= v_val;
         end
      end
   end

   a_copy_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.result_type == RT_COPY) |-> !rsp_ff.last)
      else $error("copy order flagged last");

   a_swap_flips: assert property (@(posedge clock) disable iff (reset || csr_we)
      (state_ff == BK_SWAP) |=> (active_ff != $past(active_ff)))
      else $error("sector swap did not flip active sector");

   a_active_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BK_SWAP && !csr_we) |=> $stable(active_ff))
      else $error("active sector changed outside swap");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= LAST_IDX)
      else $error("slot pointer out of range");
endmodule

// ----- hdl/kv_index_log_allocator.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tuser: kind; tdata: key_byte, value_length
// rsp     | out | rsp_tvalid/tready    | tuser: result_type; tdata: see port; tlast: last
// csr     | in  | csr_we               | csr_index, csr_data
// Key bytes are taken whenever the command queue has room. Get/delete scan every slot (one
// table read and one compare per slot on the single memory read port). A set that compacts
// scans every slot again to issue copy orders, each of which can stall on rsp_tready.
// Reset and any csr write clear the table, cursors and key hash.
// A two-entry command queue lets key bytes and commands arrive while the back end works.
module kv_index_log_allocator #(
   parameter int PAIRS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // kind
   input  logic [23:0]   req_tdata,   // key_byte, value_length
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic          rsp_tuser,   // result_type
   // status, slot, data_address, source_address, length, record_address,
   // key_id, switched, zero pad
   output logic [151:0]  rsp_tdata,
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [31:0]   csr_data
);
   import kvila_pkg::*;

   logic    q_full, q_push, q_pop, q_empty;
   cmd_type q_wcmd, q_rcmd;
   rsp_type rsp;

   kvila_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_wcmd)
   );

   kvila_fifo #(.W($bits(cmd_type))) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wcmd),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rcmd),
      .empty (q_empty)
   );

   kvila_back #(.PAIRS(PAIRS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_empty   (q_empty),
      .q_cmd     (q_rcmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.result_type;
   assign rsp_tlast = rsp.last;
   assign rsp_tdata = {1'b0, rsp.switched, rsp.key_id, rsp.record_address, rsp.length,
                       rsp.source_address, rsp.data_address, rsp.slot, rsp.status};
endmodule
